@@ src/jts_pkg.sv @@
package jts_pkg;

  // scan modes
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ESCAPE = 2'd2,
    MODE_PRIM   = 2'd3
  } mode_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_INVAL = 2'd2,
    ST_PART  = 2'd3
  } status_t;

  // token kinds
  localparam logic [1:0] KIND_PRIM   = 2'd0;
  localparam logic [1:0] KIND_OBJECT = 2'd1;
  localparam logic [1:0] KIND_ARRAY  = 2'd2;
  localparam logic [1:0] KIND_STRING = 2'd3;

  // configuration register indexes
  localparam logic CFG_STRICT = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  localparam logic [9:0] COUNT_MAX = 10'd1023;

  // sequencer states
  typedef enum logic {
    SEQ_RUN  = 1'b0,
    SEQ_LOAD = 1'b1
  } seq_t;

  // one container entry: start, child count, parent, array flag
  typedef struct packed {
    logic [15:0]       start;
    logic [9:0]        count;
    logic signed [10:0] parent;
    logic              is_array;
  } cont_t;

  // one result word
  typedef struct packed {
    logic              valid;
    logic [9:0]        index;
    logic [1:0]        kind;
    logic              role;
    logic [15:0]       start;
    logic [16:0]       end_p;
    logic [9:0]        count;
    logic signed [10:0] parent;
    status_t           status;
    logic              done;
    logic              last;
  } res_t;

  // push request toward the result queue
  typedef struct packed {
    logic push;
    logic two;
    res_t w0;
    res_t w1;
  } push_t;

endpackage

@@ src/json_token_scanner.sv @@
// A byte's result words are pushed into the result queue when it is accepted.
// One byte per cycle while the queue has room; a closing brace or bracket with
// an open parent stalls the next byte while the parent entry is read from the store.
// Up to two result words per byte drain one per ready cycle from a 4-word queue.
// Reset (rst_n, synchronous): text state, queue and configuration are reset;
// the token store has no reset and needs no clearing pass.
module json_token_scanner #(
  parameter int TOKEN_SLOTS = 1024,
  parameter int MAX_TEXT    = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  // token_index[9:0] token_kind[11:10] pair_role[12] start_pos[28:13]
  // end_pos[45:29] child_count[55:46] parent_index[66:56] status[68:67]
  // text_done[69]
  output logic [71:0] out_tdata,
  output logic        out_tuser,  // token_valid
  output logic        out_tlast,  // last_result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import jts_pkg::*;

  localparam int AW = (TOKEN_SLOTS > 1) ? $clog2(TOKEN_SLOTS) : 1;
  localparam int PW = $clog2(MAX_TEXT + 1);

  logic          in_fire;
  logic          accept_ok;
  logic          q_room;
  push_t         push;
  res_t          ow;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  cont_t         wr_data, rd_data;

  assign cfg_ready = 1'b1;
  assign in_tready = accept_ok;
  assign in_fire   = in_tvalid && accept_ok;

  jts_scan #(
    .TOKEN_SLOTS(TOKEN_SLOTS), .MAX_TEXT(MAX_TEXT), .AW(AW), .PW(PW)
  ) u_scan (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_fire), .in_byte(in_tdata), .in_end(in_tlast),
    .cfg_fire(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .q_room(q_room), .accept_ok(accept_ok), .push(push),
    .st_wr_en(wr_en), .st_wr_addr(wr_addr), .st_wr_data(wr_data),
    .st_rd_en(rd_en), .st_rd_addr(rd_addr), .st_rd_data(rd_data)
  );

  jts_store #(.AW(AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  jts_outq u_outq (
    .clk(clk), .rst_n(rst_n), .req(push), .room(q_room),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_word(ow)
  );

  // word packing
  assign out_tdata = {2'b00, ow.done, ow.status, ow.parent, ow.count, ow.end_p,
                      ow.start, ow.role, ow.kind, ow.index};
  assign out_tuser = ow.valid;
  assign out_tlast = ow.last;

endmodule

@@ src/jts_store.sv @@
module jts_store #(
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  jts_pkg::cont_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output jts_pkg::cont_t  rd_data
);
  import jts_pkg::*;

  cont_t mem [2**AW];
  cont_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/jts_outq.sv @@
module jts_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  jts_pkg::push_t  req,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output jts_pkg::res_t   out_word
);
  import jts_pkg::*;

  res_t       q_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [2:0] add;

  assign pop       = out_valid && out_ready;
  assign add       = !req.push ? 3'd0 : (req.two ? 3'd2 : 3'd1);
  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_word  = q_r[rp_r];

  // pointers and fill count
  always_comb begin
    wp_nxt  = wp_r + add[1:0];
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + add - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (req.push) begin
      q_r[wp_r] <= req.w0;
      if (req.two) begin
        q_r[wp_r + 2'd1] <= req.w1;
      end
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overfilled");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> room)
    else $error("push without room");
  a_empty_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 && !req.push) |=> cnt_r == 3'd0)
    else $error("queue count moved without push");

endmodule

@@ src/jts_scan.sv @@
module jts_scan #(
  parameter int TOKEN_SLOTS = 1024,
  parameter int MAX_TEXT    = 65536,
  parameter int AW          = 10,
  parameter int PW          = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  logic            cfg_fire,
  input  logic            cfg_idx,
  input  logic [10:0]     cfg_val,
  input  logic            q_room,
  output logic            accept_ok,
  output jts_pkg::push_t  push,
  output logic            st_wr_en,
  output logic [AW-1:0]   st_wr_addr,
  output jts_pkg::cont_t  st_wr_data,
  output logic            st_rd_en,
  output logic [AW-1:0]   st_rd_addr,
  input  jts_pkg::cont_t  st_rd_data
);
  import jts_pkg::*;

  // configuration
  logic        strict_r;
  logic [10:0] limit_r;

  // text state
  seq_t               seq_r, seq_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [10:0]        nt_r, nt_nxt;
  logic signed [10:0] enc_r, enc_nxt;
  logic [10:0]        dep_r, dep_nxt;
  mode_t              mode_r, mode_nxt;
  logic [15:0]        is_r, is_nxt;
  logic               en_r, en_nxt;
  status_t            err_r, err_nxt;

  // cached entry of the innermost open container
  cont_t              cc_r, cc_nxt;

  logic [10:0]        lim;
  logic [PW-1:0]      pos_inc;
  logic               alloc_ok;
  status_t            st;
  logic               go;
  logic               prim_hit, str_hit, close_hit;
  logic [16:0]        prim_end;
  logic [15:0]        prim_start;
  logic [9:0]         prim_idx, str_idx;
  logic signed [10:0] prim_par;
  logic               str_role;
  res_t               rec_prim, rec_str, rec_close, r0, r1;
  logic               rd_go;

  function automatic logic [9:0] sat_inc(input logic [9:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 10'd1;
  endfunction

  function automatic logic ends_prim(input logic [7:0] b, input logic strict);
    ends_prim = (b == 8'h3A && !strict) || b == 8'h09 || b == 8'h0D || b == 8'h0A ||
                b == 8'h20 || b == 8'h2C || b == 8'h5D || b == 8'h7D;
  endfunction

  function automatic logic is_ctrl(input logic [7:0] b);
    is_ctrl = (b < 8'd32) || (b >= 8'd127);
  endfunction

  // effective slot limit
  always_comb begin
    if (32'(limit_r) < TOKEN_SLOTS) lim = limit_r;
    else                            lim = 11'(TOKEN_SLOTS);
  end

  assign pos_inc = pos_r + PW'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
      limit_r  <= 11'd1024;
    end else if (cfg_fire) begin
      unique case (cfg_idx)
        CFG_STRICT: strict_r <= cfg_val[0];
        CFG_LIMIT:  limit_r  <= cfg_val;
        default:    ;
      endcase
    end
  end

  // byte scan: next state, records and store accesses
  always_comb begin
    pos_nxt = pos_r; nt_nxt = nt_r; enc_nxt = enc_r; dep_nxt = dep_r;
    mode_nxt = mode_r; is_nxt = is_r; en_nxt = en_r; err_nxt = err_r;
    cc_nxt = cc_r;
    st = err_r; go = 1'b0;
    prim_hit = 1'b0; str_hit = 1'b0; close_hit = 1'b0;
    prim_end = '0; prim_start = '0; prim_idx = '0; prim_par = '0;
    str_idx = '0; str_role = 1'b0;
    rec_close = '0;
    st_wr_en = 1'b0; st_wr_addr = '0; st_wr_data = cc_r;
    rd_go = 1'b0; st_rd_addr = '0;
    alloc_ok = 1'b0;

    if (seq_r == SEQ_LOAD) begin
      cc_nxt = st_rd_data;
    end

    if (in_fire && err_r == ST_OK) begin
      if (32'(pos_r) >= MAX_TEXT) begin
        st = ST_INVAL;
      end else begin
        st = ST_OK;
        pos_nxt = pos_inc;
        unique case (mode_r)
          MODE_STRING: begin
            if (in_byte == 8'h22) begin
              if (nt_nxt < lim) begin
                str_hit = 1'b1; str_idx = nt_nxt[9:0]; str_role = !en_nxt;
                nt_nxt = nt_nxt + 11'd1;
                if (!enc_nxt[10]) cc_nxt.count = sat_inc(cc_nxt.count);
                mode_nxt = MODE_NORMAL;
              end else begin
                st = ST_NOMEM;
              end
            end else if (in_byte == 8'h5C) begin
              mode_nxt = MODE_ESCAPE;
            end
          end
          MODE_ESCAPE: begin
            if (in_byte == 8'h22 || in_byte == 8'h2F || in_byte == 8'h5C ||
                in_byte == 8'h62 || in_byte == 8'h66 || in_byte == 8'h72 ||
                in_byte == 8'h6E || in_byte == 8'h74 || in_byte == 8'h75) begin
              mode_nxt = MODE_STRING;
            end else begin
              st = ST_INVAL;
            end
          end
          MODE_PRIM: begin
            if (!ends_prim(in_byte, strict_r)) begin
              if (is_ctrl(in_byte)) st = ST_INVAL;
            end else if (nt_nxt < lim) begin
              prim_hit = 1'b1; prim_idx = nt_nxt[9:0]; prim_par = enc_nxt;
              prim_end = 17'(pos_r);
              prim_start = is_r;
              nt_nxt = nt_nxt + 11'd1;
              if (!enc_nxt[10]) cc_nxt.count = sat_inc(cc_nxt.count);
              mode_nxt = MODE_NORMAL;
              go = 1'b1;
            end else begin
              st = ST_NOMEM;
            end
          end
          MODE_NORMAL: go = 1'b1;
          default: ;
        endcase

        if (go) begin
          priority if (in_byte == 8'h7B || in_byte == 8'h5B) begin
            alloc_ok = (nt_nxt < lim);
            if (alloc_ok) begin
              if (!enc_nxt[10]) begin
                st_wr_en = 1'b1;
                st_wr_addr = AW'(unsigned'(enc_nxt));
                st_wr_data = cc_nxt;
                st_wr_data.count = sat_inc(cc_nxt.count);
              end
              cc_nxt.start = 16'(pos_r);
              cc_nxt.count = '0;
              cc_nxt.parent = enc_nxt;
              cc_nxt.is_array = (in_byte == 8'h5B);
              enc_nxt = signed'(nt_nxt);
              nt_nxt = nt_nxt + 11'd1;
              dep_nxt = dep_nxt + 11'd1;
              if (in_byte == 8'h7B) en_nxt = 1'b1;
            end else begin
              st = ST_NOMEM;
            end
          end else if (in_byte == 8'h7D || in_byte == 8'h5D) begin
            if (enc_nxt[10] || cc_nxt.is_array != (in_byte == 8'h5D)) begin
              st = ST_INVAL;
            end else begin
              close_hit = 1'b1;
              rec_close.valid  = 1'b1;
              rec_close.index  = enc_nxt[9:0];
              rec_close.kind   = cc_nxt.is_array ? KIND_ARRAY : KIND_OBJECT;
              rec_close.role   = 1'b1;
              rec_close.start  = cc_nxt.start;
              rec_close.end_p  = 17'(pos_inc);
              rec_close.count  = cc_nxt.count;
              rec_close.parent = cc_nxt.parent;
              rd_go = !cc_nxt.parent[10];
              st_rd_addr = AW'(unsigned'(cc_nxt.parent));
              enc_nxt = cc_nxt.parent;
              if (dep_nxt != 11'd0) dep_nxt = dep_nxt - 11'd1;
            end
          end else if (in_byte == 8'h2C) begin
            if (!enc_nxt[10] && !cc_nxt.is_array) en_nxt = 1'b1;
          end else if (in_byte == 8'h22) begin
            mode_nxt = MODE_STRING;
            is_nxt = 16'(pos_inc);
          end else if (in_byte == 8'h3A) begin
            en_nxt = 1'b0;
          end else if (in_byte == 8'h09 || in_byte == 8'h0D || in_byte == 8'h0A ||
                       in_byte == 8'h20) begin
            st = ST_OK;
          end else begin
            if (strict_r && !(in_byte == 8'h2D || (in_byte >= 8'h30 && in_byte <= 8'h39) ||
                              in_byte == 8'h74 || in_byte == 8'h66 || in_byte == 8'h6E)) begin
              st = ST_INVAL;
            end else if (is_ctrl(in_byte)) begin
              st = ST_INVAL;
            end else begin
              is_nxt = 16'(pos_r);
              mode_nxt = MODE_PRIM;
            end
          end
        end
      end

      // end of text checks
      if (st == ST_OK && in_end) begin
        if (mode_nxt == MODE_STRING || mode_nxt == MODE_ESCAPE) begin
          st = ST_PART;
        end else if (mode_nxt == MODE_PRIM) begin
          if (strict_r) begin
            st = ST_PART;
          end else if (nt_nxt < lim) begin
            prim_hit = 1'b1; prim_idx = nt_nxt[9:0]; prim_par = enc_nxt;
            prim_end = 17'(pos_nxt);
            prim_start = is_nxt;
            nt_nxt = nt_nxt + 11'd1;
            mode_nxt = MODE_NORMAL;
          end else begin
            st = ST_NOMEM;
          end
        end
        if (st == ST_OK && dep_nxt != 11'd0) st = ST_PART;
      end
      err_nxt = st;
    end

    // new text after the final byte
    if (in_fire && in_end) begin
      pos_nxt = '0; nt_nxt = '0; enc_nxt = -11'sd1; dep_nxt = '0;
      mode_nxt = MODE_NORMAL; is_nxt = '0; en_nxt = 1'b0; err_nxt = ST_OK;
    end
  end

  assign st_rd_en = rd_go;

  // record assembly
  always_comb begin
    rec_prim = '0;
    rec_prim.valid  = 1'b1;
    rec_prim.index  = prim_idx;
    rec_prim.kind   = KIND_PRIM;
    rec_prim.role   = 1'b1;
    rec_prim.start  = prim_start;
    rec_prim.end_p  = prim_end;
    rec_prim.parent = prim_par;
    rec_str = '0;
    rec_str.valid  = 1'b1;
    rec_str.index  = str_idx;
    rec_str.kind   = KIND_STRING;
    rec_str.role   = str_role;
    rec_str.start  = is_r;
    rec_str.end_p  = 17'(pos_r);
    rec_str.parent = enc_r;

    priority if (prim_hit)  r0 = rec_prim;
    else if (str_hit)       r0 = rec_str;
    else if (close_hit)     r0 = rec_close;
    else                    r0 = '0;
    r1 = rec_close;

    r0.status = st; r0.done = in_end; r0.last = !(prim_hit && close_hit);
    r1.status = st; r1.done = in_end; r1.last = 1'b1;

    push.push = in_fire;
    push.two  = prim_hit && close_hit;
    push.w0   = r0;
    push.w1   = r1;
  end

  // sequencer next state
  always_comb begin
    unique case (seq_r)
      SEQ_RUN:  seq_nxt = (in_fire && rd_go) ? SEQ_LOAD : SEQ_RUN;
      SEQ_LOAD: seq_nxt = SEQ_RUN;
      default:  seq_nxt = SEQ_RUN;
    endcase
  end

  // sequencer outputs
  always_comb begin
    unique case (seq_r)
      SEQ_RUN:  accept_ok = q_room;
      SEQ_LOAD: accept_ok = 1'b0;
      default:  accept_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= SEQ_RUN;
      pos_r  <= '0;
      nt_r   <= '0;
      enc_r  <= -11'sd1;
      dep_r  <= '0;
      mode_r <= MODE_NORMAL;
      is_r   <= '0;
      en_r   <= 1'b0;
      err_r  <= ST_OK;
    end else begin
      seq_r  <= seq_nxt;
      pos_r  <= pos_nxt;
      nt_r   <= nt_nxt;
      enc_r  <= enc_nxt;
      dep_r  <= dep_nxt;
      mode_r <= mode_nxt;
      is_r   <= is_nxt;
      en_r   <= en_nxt;
      err_r  <= err_nxt;
    end
  end

  // container cache is payload
  always_ff @(posedge clk) begin
    cc_r <= cc_nxt;
  end

  a_depth_enc: assert property (@(posedge clk) disable iff (!rst_n)
    (dep_r == 11'd0) == (enc_r == -11'sd1))
    else $error("open depth and enclosing container disagree");
  a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_RUN && in_fire && st_rd_en) |=> seq_r == SEQ_LOAD)
    else $error("store read without cache load");
  a_no_fire_load: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SEQ_LOAD |-> !in_fire)
    else $error("byte taken while cache loads");
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_wr_en && st_rd_en))
    else $error("store read and write in one byte");

endmodule
